// File: hdl/srmv_pkg.sv
// ----------------------------------------------------------------------------
// srmv_pkg
// Types and constants shared by the sparse row matrix-vector multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package srmv_pkg;

    localparam int unsigned INDEX_W     = 10;
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned ROW_W       = 16;
    localparam int unsigned HALF_W      = DATA_W / 2;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    // word index of the num_rows register
    localparam logic REG_NUM_ROWS = 1'b0;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_NONZERO = 2'd1,
        ACT_EMPTY   = 2'd2
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic [INDEX_W-1:0]        index;
        logic signed [DATA_W-1:0]  value;
        logic                      row_end;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  row_sum;
        logic [ROW_W-1:0]          row_number;
        logic                      last_row;
    } t_out_item;

    // one classified item handed from the front to the back
    typedef struct packed {
        logic                      is_empty;
        logic                      row_end;
        logic [DATA_W-1:0]         value;
        logic [DATA_W-1:0]         xval;
    } t_work;

    // per-stage control in the back pipeline
    typedef struct packed {
        logic                      valid;
        logic                      is_empty;
        logic                      row_end;
    } t_stage_ctl;

endpackage

`default_nettype wire

// File: hdl/srmv_ram.sv
// ----------------------------------------------------------------------------
// srmv_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srmv_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/srmv_front.sv
// ----------------------------------------------------------------------------
// srmv_front
// Accepts input beats, writes vector loads into the store and reads the
// vector entry for each nonzero; passes nonzero and empty-row work on.
// ----------------------------------------------------------------------------
`default_nettype none

module srmv_front #(
    parameter int unsigned VECTOR_DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire srmv_pkg::t_in_item i_in_item,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output srmv_pkg::t_work        o_q_data
);
    import srmv_pkg::*;

    localparam int unsigned AW    = $clog2(VECTOR_DEPTH);
    localparam int unsigned EXT_W = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

    logic              w_accept;
    logic              w_is_load;
    logic              w_is_work;
    logic [EXT_W-1:0]  w_idx_ext;
    logic              w_in_range;
    logic              w_ram_en;
    logic              w_ram_we;
    logic [DATA_W-1:0] w_rdata;
    logic              w_s1_load;

    logic              r_s1_valid;
    logic              n_s1_valid;
    logic              r_s1_empty;
    logic              r_s1_row_end;
    logic              r_s1_in_range;
    logic [DATA_W-1:0] r_s1_value;

    assign o_in_ready = !r_s1_valid || !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_load  = (i_in_item.action == ACT_LOAD);
    assign w_is_work  = (i_in_item.action == ACT_NONZERO) || (i_in_item.action == ACT_EMPTY);
    assign w_idx_ext  = EXT_W'(i_in_item.index);
    assign w_in_range = w_idx_ext < EXT_W'(VECTOR_DEPTH);

    assign w_ram_we = w_accept && w_is_load && w_in_range;
    assign w_ram_en = w_ram_we ||
                      (w_accept && (i_in_item.action == ACT_NONZERO) && w_in_range);

    srmv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_idx_ext[AW-1:0]),
        .i_wdata (i_in_item.value),
        .o_rdata (w_rdata)
    );

    assign w_s1_load = !r_s1_valid || !i_q_full;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_s1_load) begin
            n_s1_valid = w_accept && w_is_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && w_accept) begin
            r_s1_empty    <= (i_in_item.action == ACT_EMPTY);
            r_s1_row_end  <= i_in_item.row_end;
            r_s1_in_range <= w_in_range;
            r_s1_value    <= i_in_item.value;
        end
    end

    assign o_q_push          = r_s1_valid && !i_q_full;
    assign o_q_data.is_empty = r_s1_empty;
    assign o_q_data.row_end  = r_s1_row_end;
    assign o_q_data.value    = r_s1_value;
    assign o_q_data.xval     = r_s1_in_range ? w_rdata : '0;

`ifndef SYNTHESIS
    a_load_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_load) |=> !r_s1_valid)
        else $error("load beat entered the work stage");
`endif

endmodule

`default_nettype wire

// File: hdl/srmv_queue.sv
// ----------------------------------------------------------------------------
// srmv_queue
// Short FIFO of classified work between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module srmv_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire srmv_pkg::t_work i_data,
    input  wire logic           i_pop,
    output srmv_pkg::t_work     o_data,
    output logic                o_full,
    output logic                o_empty
);
    import srmv_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_work           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// File: hdl/srmv_back.sv
// ----------------------------------------------------------------------------
// srmv_back
// Multiplies each nonzero by its vector entry in split 32-bit partial
// products, accumulates per row and emits row sums into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srmv_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [srmv_pkg::ROW_W-1:0]     i_num_rows,
    input  wire srmv_pkg::t_work                i_q_data,
    input  wire logic                           i_q_empty,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output srmv_pkg::t_out_item                 o_out_item
);
    import srmv_pkg::*;

    logic               w_adv;
    logic [HALF_W-1:0]  w_a_lo;
    logic [HALF_W-1:0]  w_a_hi;
    logic [HALF_W-1:0]  w_b_lo;
    logic [HALF_W-1:0]  w_b_hi;
    logic [DATA_W-1:0]  w_pp0;
    logic [HALF_W-1:0]  w_pp1;
    logic [HALF_W-1:0]  w_pp2;
    logic [DATA_W-1:0]  w_sum;
    logic [ROW_W-1:0]   w_last;
    logic               w_emit;

    t_stage_ctl         r_b1;
    t_stage_ctl         r_b2;
    t_stage_ctl         n_b1;
    logic [DATA_W-1:0]  r_pp0;
    logic [HALF_W-1:0]  r_pp1;
    logic [HALF_W-1:0]  r_pp2;
    logic [DATA_W-1:0]  r_prod;

    logic [DATA_W-1:0]  r_acc;
    logic [DATA_W-1:0]  n_acc;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   n_row;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out_item;

    assign w_adv   = !r_out_valid || i_out_ready;
    assign o_q_pop = w_adv && !i_q_empty;

    assign w_a_lo = i_q_data.value[HALF_W-1:0];
    assign w_a_hi = i_q_data.value[DATA_W-1:HALF_W];
    assign w_b_lo = i_q_data.xval[HALF_W-1:0];
    assign w_b_hi = i_q_data.xval[DATA_W-1:HALF_W];
    assign w_pp0  = w_a_lo * w_b_lo;
    assign w_pp1  = w_a_lo * w_b_hi;
    assign w_pp2  = w_a_hi * w_b_lo;

    always_comb begin
        n_b1.valid    = !i_q_empty;
        n_b1.is_empty = i_q_data.is_empty;
        n_b1.row_end  = i_q_data.row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1 <= '0;
            r_b2 <= '0;
        end else if (w_adv) begin
            r_b1 <= n_b1;
            r_b2 <= r_b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pp0  <= w_pp0;
            r_pp1  <= w_pp1;
            r_pp2  <= w_pp2;
            r_prod <= r_pp0 + {r_pp1 + r_pp2, HALF_W'(0)};
        end
    end

    assign w_sum  = r_acc + r_prod;
    assign w_last = i_num_rows - ROW_W'(1);
    assign w_emit = r_b2.valid && (r_b2.is_empty || r_b2.row_end);

    always_comb begin
        n_acc       = r_acc;
        n_row       = r_row;
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_adv && r_b2.valid) begin
            n_acc = w_emit ? '0 : w_sum;
            if (w_emit) begin
                n_out_valid = 1'b1;
                n_row = (r_row >= w_last) ? '0 : r_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_item.row_sum    <= r_b2.is_empty ? '0 : w_sum;
            r_out_item.row_number <= r_row;
            r_out_item.last_row   <= (r_row == w_last);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_empty_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_b2.valid && r_b2.is_empty) |=> (r_acc == '0))
        else $error("empty row left a partial sum");

    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_b2.valid))
        else $error("result without a finished row");

    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |=> (r_row != $past(r_row) || i_num_rows == ROW_W'(1)))
        else $error("row counter did not advance on emit");
`endif

endmodule

`default_nettype wire

// File: hdl/sparse_row_matvec_top.sv
// ----------------------------------------------------------------------------
// sparse_row_matvec_top
// Sparse matrix times dense vector over a compressed-row item stream.
//
// Input channel (i_in_valid/o_in_ready, i_in_item): load beats write the
// vector store, nonzero beats multiply a matrix value by the stored entry
// and add it to the current row, empty-row beats emit a zero row sum.
// Output channel (o_out_valid/i_out_ready, o_out_item): one beat per
// finished row with its sum, row number and last-row flag.
// APB port: word 0 holds num_rows (reset 1, zero means 65536 rows).
// Throughput: one input beat per cycle unless the queue is full or the
// receiver stalls, set by the single vector RAM port and the accumulate loop.
// A row sum passes the front stage, queue, r_b1, r_b2 and output register.
// A four-entry queue sits between the front and the multiply pipeline; when
// the receiver stalls, the pipeline holds, the queue fills and o_in_ready
// drops; load beats keep flowing while the front stage is free.
// Reset clears the row counter, accumulator, queue and valid flags; the
// vector store holds unknown data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_row_matvec_top #(
    parameter int unsigned VECTOR_DEPTH = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire srmv_pkg::t_in_item                  i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output srmv_pkg::t_out_item                      o_out_item,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [srmv_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [srmv_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [srmv_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);
    import srmv_pkg::*;

    logic [ROW_W-1:0] r_rows;
    logic             w_reg_sel;
    logic             w_cfg_wr;
    logic             w_q_full;
    logic             w_q_empty;
    logic             w_q_push;
    logic             w_q_pop;
    t_work            w_q_in;
    t_work            w_q_out;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[APB_ADDR_W-1] == REG_NUM_ROWS);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_reg_sel;
    assign prdata    = w_reg_sel ? APB_DATA_W'(r_rows) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROW_W'(1);
        end else begin
            if (w_cfg_wr) begin
                r_rows <= pwdata[ROW_W-1:0];
            end
        end
    end

    srmv_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_in)
    );

    srmv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    srmv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num_rows  (r_rows),
        .i_q_data    (w_q_out),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_cfg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_rows == $past(pwdata[ROW_W-1:0])))
        else $error("row count write lost");
`endif

endmodule

`default_nettype wire
